>>> rtl/mic_pkg.sv
// shared types and constants for the masked interrupt controller
`timescale 1ns / 1ps

package mic_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    // field widths
    localparam int KIND_W   = 2;
    localparam int LINE_W   = 5;
    localparam int OFFSET_W = 12;
    localparam int COUNT_W  = 6;

    // register byte offsets
    localparam logic [OFFSET_W-1:0] OFS_STATUS      = 12'h000;
    localparam logic [OFFSET_W-1:0] OFS_NUMBER      = 12'h004;
    localparam logic [OFFSET_W-1:0] OFS_DISABLE_ALL = 12'h008;
    localparam logic [OFFSET_W-1:0] OFS_DISABLE     = 12'h00c;
    localparam logic [OFFSET_W-1:0] OFS_ENABLE      = 12'h010;

endpackage

>>> rtl/masked_interrupt_controller.sv
// masked level interrupt controller: line changes, bus reads and bus writes
// result valid in the output register in the cycle after item accept;
// one item per cycle unless a held result stalls; state update and result
// are computed at accept, the result register decouples the output side
// reset: levels, enable mask and pending count clear to zero, no result held
`timescale 1ns / 1ps

module masked_interrupt_controller
    import mic_pkg::*;
#(
    parameter int NUM_LINES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [LINE_W-1:0]   line_index,
    input  logic                line_value,
    input  logic [OFFSET_W-1:0] bus_offset,
    input  logic [LINE_W-1:0]   write_number,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COUNT_W-1:0]  read_data,
    output logic                irq_out,
    output logic                bad_offset
);

    // controller state
    logic [NUM_LINES-1:0] line_levels_reg, line_levels_next;
    logic [NUM_LINES-1:0] enable_mask_reg, enable_mask_next;
    logic [COUNT_W-1:0]   pending_total_reg, pending_total_next;

    // result register
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   read_data_reg, read_data_next;
    logic                 irq_reg, irq_next;
    logic                 bad_reg, bad_next;

    logic                 accept;
    logic [NUM_LINES-1:0] active;
    logic [COUNT_W-1:0]   lowest;
    logic [NUM_LINES-1:0] line_mask;
    logic [NUM_LINES-1:0] wr_mask;

    // handshake: hold off input only while a result waits and is stalled
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // one-hot line masks; an index at or above NUM_LINES shifts out to zero
    assign line_mask = {{(NUM_LINES-1){1'b0}}, 1'b1} << line_index;
    assign wr_mask   = {{(NUM_LINES-1){1'b0}}, 1'b1} << write_number;

    assign active = line_levels_reg & enable_mask_reg;

    // priority encoder for the lowest pending line
    always_comb
    begin
        lowest = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--)
        begin
            if (active[i])
            begin
                lowest = COUNT_W'(i);
            end
        end
    end

    // next state and result for the item at the input
    always_comb
    begin
        line_levels_next   = line_levels_reg;
        enable_mask_next   = enable_mask_reg;
        pending_total_next = pending_total_reg;
        read_data_next     = '0;
        bad_next           = 1'b0;
        case (kind_t'(kind))
            KIND_LINE:
            begin
                if (line_value)
                begin
                    if ((line_levels_reg & line_mask) == '0)
                    begin
                        if ((enable_mask_reg & line_mask) != '0)
                        begin
                            pending_total_next = pending_total_reg + COUNT_W'(1);
                        end
                        line_levels_next = line_levels_reg | line_mask;
                    end
                end
                else if ((line_levels_reg & line_mask) != '0)
                begin
                    if ((enable_mask_reg & line_mask) != '0)
                    begin
                        pending_total_next = pending_total_reg - COUNT_W'(1);
                    end
                    line_levels_next = line_levels_reg & ~line_mask;
                end
            end
            KIND_READ:
            begin
                if (bus_offset == OFS_STATUS)
                begin
                    read_data_next = pending_total_reg;
                end
                else if (bus_offset == OFS_NUMBER)
                begin
                    read_data_next = lowest;
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            KIND_WRITE:
            begin
                if (bus_offset == OFS_DISABLE_ALL)
                begin
                    line_levels_next   = '0;
                    pending_total_next = '0;
                end
                else if (bus_offset == OFS_DISABLE)
                begin
                    if ((enable_mask_reg & wr_mask) != '0)
                    begin
                        if ((line_levels_reg & wr_mask) != '0)
                        begin
                            pending_total_next = pending_total_reg - COUNT_W'(1);
                        end
                        enable_mask_next = enable_mask_reg & ~wr_mask;
                    end
                end
                else if (bus_offset == OFS_ENABLE)
                begin
                    if ((enable_mask_reg & wr_mask) == '0)
                    begin
                        if ((line_levels_reg & wr_mask) != '0)
                        begin
                            pending_total_next = pending_total_reg + COUNT_W'(1);
                        end
                        enable_mask_next = enable_mask_reg | wr_mask;
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            default:
            begin
                // unused kind: nothing changes
            end
        endcase
        irq_next = |(line_levels_next & enable_mask_next);
    end

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_levels_reg   <= '0;
            enable_mask_reg   <= '0;
            pending_total_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                line_levels_reg   <= line_levels_next;
                enable_mask_reg   <= enable_mask_next;
                pending_total_reg <= pending_total_next;
                out_valid_reg     <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
            bad_reg       <= bad_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign irq_out    = irq_reg;
    assign bad_offset = bad_reg;

    // an accepted item always shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
    else $error("accepted item produced no result");

    // a held result reports irq consistent with the current state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (irq_reg == (|active)))
    else $error("irq result disagrees with state");

    // pending count tracks the number of high and enabled lines
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_total_reg == COUNT_W'($countones(active)))
    else $error("pending count out of step with levels and mask");

    // a bad offset never returns data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |-> (read_data_reg == '0))
    else $error("bad offset returned nonzero data");

endmodule
